// File: rtl/core/thfam_pkg.sv
`default_nettype none
package thfam_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PRESCALE   = 32 - SAMPLE_W;
    localparam int SQRT_CELLS = 32;
    localparam int OPER_W     = 40;
    localparam int ACC_W      = 34;
    localparam int ANGLE_FRAC = 16;

    localparam logic [1:0] REG_DECL = 2'd0;

    localparam logic signed [ACC_W-1:0] HALF_TURN_ACC = 34'sd1179648000;

    // atan(2^-i) in 2^-16 centidegree units
    localparam logic [31:0] ATAN_TABLE [0:31] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
        32'd11730358, 32'd5866610, 32'd2933484, 32'd1466764, 32'd733389,
        32'd366693, 32'd183346, 32'd91673, 32'd45837, 32'd22918, 32'd11459,
        32'd5730, 32'd2865, 32'd1432, 32'd716, 32'd358, 32'd179, 32'd90,
        32'd45, 32'd22, 32'd11, 32'd6, 32'd3, 32'd1, 32'd1, 32'd0, 32'd0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] mag_x;
        logic signed [SAMPLE_W-1:0] mag_y;
        logic signed [SAMPLE_W-1:0] mag_z;
    } sample_t;

    typedef struct packed {
        logic signed [14:0] pitch_centideg;
        logic signed [15:0] roll_centideg;
        logic signed [15:0] heading_centideg;
    } angles_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        sample_t     side;
    } sqrt_t;

    typedef struct packed {
        logic signed [OPER_W-1:0] x;
        logic signed [OPER_W-1:0] y;
        logic signed [ACC_W-1:0]  acc;
        logic                     ovr;
        logic signed [15:0]       ovr_val;
    } cord_t;

endpackage
`default_nettype wire

// File: rtl/core/thfam_sqrt_cell.sv
`default_nettype none
module thfam_sqrt_cell #(
    parameter int STAGE = 0
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  thfam_pkg::sqrt_t     d,
    output thfam_pkg::sqrt_t     q_reg
);
    import thfam_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_CELLS - 1 - STAGE));

    logic [63:0] trial;
    sqrt_t       q_next;

    always_comb
    begin
        trial  = d.root + BIT;
        q_next = d;
        if (d.rem >= trial)
        begin
            q_next.rem  = d.rem - trial;
            q_next.root = (d.root >> 1) + BIT;
        end
        else
        begin
            q_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/thfam_cordic_cell.sv
`default_nettype none
module thfam_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  thfam_pkg::cord_t     d,
    output thfam_pkg::cord_t     q_reg
);
    import thfam_pkg::*;

    localparam logic signed [ACC_W-1:0] ANG = ACC_W'(ATAN_TABLE[STAGE]);

    logic signed [OPER_W-1:0] xs;
    logic signed [OPER_W-1:0] ys;
    cord_t                    q_next;

    always_comb
    begin
        xs     = d.x >>> STAGE;
        ys     = d.y >>> STAGE;
        q_next = d;
        if (!d.y[OPER_W-1])
        begin
            q_next.x   = d.x + ys;
            q_next.y   = d.y - xs;
            q_next.acc = d.acc + ANG;
        end
        else
        begin
            q_next.x   = d.x - ys;
            q_next.y   = d.y + xs;
            q_next.acc = d.acc - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/thfam_atan2.sv
`default_nettype none
module thfam_atan2 #(
    parameter int STAGES = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [thfam_pkg::OPER_W-1:0]   y,
    input  wire logic signed [thfam_pkg::OPER_W-1:0]   x,
    input  wire logic                                  x_zero_rule,
    output logic signed [15:0]                         angle
);
    import thfam_pkg::*;

    cord_t init_next;
    cord_t init_reg;
    cord_t stg [0:STAGES];

    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] sh;

    // x_zero_rule: x == 0 gives 180 deg for negative y, else 0
    always_comb
    begin
        init_next         = '0;
        init_next.x       = x;
        init_next.y       = y;
        if (y == '0)
        begin
            init_next.ovr     = 1'b1;
            init_next.ovr_val = x[OPER_W-1] ? 16'sd18000 : 16'sd0;
        end
        else if (x == '0)
        begin
            init_next.ovr = 1'b1;
            if (x_zero_rule)
            begin
                init_next.ovr_val = y[OPER_W-1] ? 16'sd18000 : 16'sd0;
            end
            else
            begin
                init_next.ovr_val = y[OPER_W-1] ? -16'sd9000 : 16'sd9000;
            end
        end
        else if (x[OPER_W-1])
        begin
            init_next.x   = -x;
            init_next.y   = -y;
            init_next.acc = y[OPER_W-1] ? -HALF_TURN_ACC : HALF_TURN_ACC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            init_reg <= init_next;
        end
    end

    assign stg[0] = init_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        thfam_cordic_cell #(.STAGE(i)) u_cell (
            .clk   (clk),
            .en    (en),
            .d     (stg[i]),
            .q_reg (stg[i+1])
        );
    end

    always_comb
    begin
        rnd = stg[STAGES].acc + ACC_W'(1 << (ANGLE_FRAC - 1));
        sh  = rnd >>> ANGLE_FRAC;
        if (stg[STAGES].ovr)
        begin
            angle = stg[STAGES].ovr_val;
        end
        else if (sh > ACC_W'(18000))
        begin
            angle = 16'sd18000;
        end
        else if (sh < -ACC_W'(18000))
        begin
            angle = -16'sd18000;
        end
        else
        begin
            angle = sh[15:0];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/tilt_heading_from_accel_mag.sv
`default_nettype none
// channel    | handshake                     | payload
// sample in  | sample_valid / sample_stall   | sample (accel_x..mag_z)
// angles out | angles_valid / angles_stall   | angles (pitch, roll, heading)
// config     | APB, psel/penable/pwrite      | declination at address 0
//
// One item per cycle unless the output stalls; the pipeline is two input stages,
// 32 square root cells (one root bit each), one CORDIC setup stage, one
// CORDIC cell per stage, and the output register.
// Reset clears valid bits and sets the declination to -0.62 deg.
// A stalled output freezes the whole chain; sample_stall follows it.
module tilt_heading_from_accel_mag #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  thfam_pkg::sample_t        sample,
    output logic                      angles_valid,
    input  wire logic                 angles_stall,
    output thfam_pkg::angles_t        angles,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [1:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import thfam_pkg::*;

    localparam int NV = 35 + CORDIC_STAGES;

    logic                  adv;
    logic [NV-1:0]         vld_reg;
    logic                  out_valid_reg;
    angles_t               out_reg;
    angles_t               out_next;
    logic signed [15:0]    decl_reg;

    sample_t               p1_reg;
    logic [31:0]           sqy_reg;
    logic [31:0]           sqz_reg;
    logic signed [31:0]    sqy;
    logic signed [31:0]    sqz;
    sqrt_t                 sq0_reg;
    sqrt_t                 sq [0:SQRT_CELLS];

    sample_t               sd;
    logic signed [OPER_W-1:0] pitch_y, pitch_x, roll_y, roll_x, head_y, head_x;
    logic signed [15:0]    pitch_a, roll_a, head_a;
    logic signed [16:0]    h;

    assign adv          = !out_valid_reg || !angles_stall;
    assign sample_stall = !adv;
    assign angles_valid = out_valid_reg;
    assign angles       = out_reg;
    assign pready       = 1'b1;
    assign prdata       = {{16{decl_reg[15]}}, decl_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= -16'sd62;
        end
        else if (psel && penable && pwrite && paddr == REG_DECL)
        begin
            decl_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NV-2:0], sample_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    assign sqy = sample.accel_y * sample.accel_y;
    assign sqz = sample.accel_z * sample.accel_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= sample;
            sqy_reg <= sqy;
            sqz_reg <= sqz;
            sq0_reg.rem  <= {sqy_reg + sqz_reg, 32'd0};
            sq0_reg.root <= '0;
            sq0_reg.side <= p1_reg;
            out_reg      <= out_next;
        end
    end

    assign sq[0] = sq0_reg;

    for (genvar j = 0; j < SQRT_CELLS; j++)
    begin : g_sqrt
        thfam_sqrt_cell #(.STAGE(j)) u_sqrt (
            .clk   (clk),
            .en    (adv),
            .d     (sq[j]),
            .q_reg (sq[j+1])
        );
    end

    always_comb
    begin
        sd      = sq[SQRT_CELLS].side;
        pitch_y = -(OPER_W'(sd.accel_x) <<< PRESCALE);
        pitch_x = OPER_W'(sq[SQRT_CELLS].root[31:0]);
        roll_y  = OPER_W'(sd.accel_y) <<< PRESCALE;
        roll_x  = OPER_W'(sd.accel_z) <<< PRESCALE;
        head_y  = OPER_W'(sd.mag_x) <<< PRESCALE;
        head_x  = OPER_W'(sd.mag_y) <<< PRESCALE;
    end

    thfam_atan2 #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk (clk), .en (adv), .y (pitch_y), .x (pitch_x),
        .x_zero_rule (1'b0), .angle (pitch_a)
    );

    thfam_atan2 #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk (clk), .en (adv), .y (roll_y), .x (roll_x),
        .x_zero_rule (1'b0), .angle (roll_a)
    );

    thfam_atan2 #(.STAGES(CORDIC_STAGES)) u_head (
        .clk (clk), .en (adv), .y (head_y), .x (head_x),
        .x_zero_rule (1'b1), .angle (head_a)
    );

    always_comb
    begin
        out_next = '0;
        if (pitch_a > 16'sd9000)
        begin
            out_next.pitch_centideg = 15'sd9000;
        end
        else if (pitch_a < -16'sd9000)
        begin
            out_next.pitch_centideg = -15'sd9000;
        end
        else
        begin
            out_next.pitch_centideg = pitch_a[14:0];
        end
        out_next.roll_centideg = roll_a;
        // one wrap back into the half-turn range
        h = 17'(head_a) - 17'(decl_reg);
        if (h > 17'sd18000)
        begin
            h = h - 17'sd36000;
        end
        else if (h < -17'sd18000)
        begin
            h = h + 17'sd36000;
        end
        out_next.heading_centideg = h[15:0];
    end
endmodule
`default_nettype wire
